/* rtl/frp_pkg.sv */
// Package for the FASTA record parser: transaction types, character codes,
// register indexes. No dependencies.
package frp_pkg;

   // Register map
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_RESIDUES     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_HEADER_CHARS = 1'd1;

   localparam logic [15:0] MAX_RESIDUES_RESET     = 16'd39999;
   localparam logic [7:0]  MAX_HEADER_CHARS_RESET = 8'd198;

   // Characters
   localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_ID      = 2'd1,
      KIND_DESC    = 2'd2,
      KIND_RESIDUE = 2'd3
   } char_kind_type;

   typedef enum logic [4:0] {
      MODE_SEEK = 5'b00001,
      MODE_LEAD = 5'b00010,
      MODE_ID   = 5'b00100,
      MODE_DESC = 5'b01000,
      MODE_SEQ  = 5'b10000
   } parse_mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]  char_kind;
      logic [7:0]  char_out;
      logic        record_start;
      logic        record_end;
      logic [31:0] record_offset;
      logic [15:0] seq_length;
      logic        overflow;
      logic        illegal_skipped;
      logic        header_error;
   } rsp_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
   endfunction

   function automatic logic is_id_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF)
          || (c == CH_CR);
   endfunction

endpackage

/* rtl/fasta_record_parser_core.sv */
// FASTA record parser top level: byte-serial mode machine with a result register.
// Depends on frp_pkg.
//
// One byte (or an end-of-file mark) is taken per transaction on req_, and exactly
// one result transaction follows on rsp_. Throughput is one byte per clock: the
// mode update and the compares all sit between the request port and the result
// register, so the next byte is accepted in the same cycle the previous result is
// taken, or while the result register is empty. req_ready
// only drops while a result waits in the register and rsp_ready is low. The
// stream offset is OFFSET_WIDTH bits internally (wraps modulo 2^OFFSET_WIDTH) and
// is reported on 32 bits; the residue counter is COUNT_WIDTH bits and saturates
// into the overflow flag, reported on 16 bits. End of file closes any open
// record and restarts the offset at zero. Configuration writes on csr_ take effect
// at the next byte and are meant for idle periods only.
module fasta_record_parser_core
   import frp_pkg::*;
#(
   parameter int OFFSET_WIDTH = 32,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   // configuration
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // compare width for residue count vs. 16-bit limit
   localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   // config registers
   logic [15:0] max_residues_ff;
   logic [7:0]  max_header_chars_ff;

   // parser state
   parse_mode_type          mode_ff, mode_in;
   logic [OFFSET_WIDTH-1:0] byte_offset_ff, byte_offset_in;
   logic [OFFSET_WIDTH-1:0] start_offset_ff, start_offset_in;
   logic [7:0]              header_count_ff, header_count_in;
   logic [COUNT_WIDTH-1:0]  residue_count_ff, residue_count_in;
   logic                    overflow_ff, overflow_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_residues_ff     <= MAX_RESIDUES_RESET;
         max_header_chars_ff <= MAX_HEADER_CHARS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_RESIDUES:     max_residues_ff     <= csr_wdata;
            CSR_MAX_HEADER_CHARS: max_header_chars_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Next-state and result logic for the byte at the request port
   always_comb begin
      logic [7:0]           c;
      logic                 in_header;
      logic                 room_header;
      logic                 room_residue;
      logic [CMP_WIDTH-1:0] count_wide;
      logic [CMP_WIDTH-1:0] limit_wide;
      logic [1:0]           kind;
      logic [7:0]           ch;
      logic                 rstart, rend, illegal, herr;

      c          = req_data.in_byte;
      in_header  = (mode_ff == MODE_LEAD) || (mode_ff == MODE_ID) || (mode_ff == MODE_DESC);
      room_header = header_count_ff < max_header_chars_ff;
      count_wide = CMP_WIDTH'(residue_count_ff);
      limit_wide = CMP_WIDTH'(max_residues_ff);
      room_residue = (count_wide < limit_wide) && !(&residue_count_ff);

      kind    = KIND_NONE;
      ch      = '0;
      rstart  = 1'b0;
      rend    = 1'b0;
      illegal = 1'b0;
      herr    = 1'b0;

      mode_in          = mode_ff;
      byte_offset_in   = byte_offset_ff;
      start_offset_in  = start_offset_ff;
      header_count_in  = header_count_ff;
      residue_count_in = residue_count_ff;
      overflow_in      = overflow_ff;

      if (req_data.end_of_file) begin
         // close any open record, restart the stream
         if (mode_ff != MODE_SEEK) begin
            rend = 1'b1;
            herr = (mode_ff == MODE_LEAD);
         end
         mode_in        = MODE_SEEK;
         byte_offset_in = '0;
      end else begin
         byte_offset_in = byte_offset_ff + OFFSET_WIDTH'(1);
         if (in_header) begin
            if (c == CH_LF) begin
               herr    = (mode_ff == MODE_LEAD);
               mode_in = MODE_SEQ;
            end else if (room_header) begin
               header_count_in = header_count_ff + 8'd1;
               unique case (mode_ff)
                  MODE_LEAD: begin
                     if (!is_id_space(c)) begin
                        kind    = KIND_ID;
                        ch      = c;
                        mode_in = MODE_ID;
                     end
                  end
                  MODE_ID: begin
                     if (is_id_space(c)) begin
                        mode_in = MODE_DESC;
                     end else begin
                        kind = KIND_ID;
                        ch   = c;
                     end
                  end
                  default: begin
                     kind = KIND_DESC;
                     ch   = c;
                  end
               endcase
            end
         end else if (c == CH_GT) begin
            // new record; closes the previous one if sequence was open
            rend             = (mode_ff == MODE_SEQ);
            rstart           = 1'b1;
            mode_in          = MODE_LEAD;
            start_offset_in  = byte_offset_ff;
            header_count_in  = '0;
            residue_count_in = '0;
            overflow_in      = 1'b0;
         end else if (mode_ff == MODE_SEQ) begin
            if (is_letter(c)) begin
               if (room_residue) begin
                  residue_count_in = residue_count_ff + COUNT_WIDTH'(1);
                  kind             = KIND_RESIDUE;
                  ch               = (c >= CH_LO_A) ? (c & ~CASE_BIT) : c;
               end else begin
                  overflow_in = 1'b1;
               end
            end else if ((c != CH_SPACE) && (c != CH_TAB) && (c != CH_LF)
                         && (c != CH_CR)) begin
               illegal = 1'b1;
            end
         end else begin
            mode_in = MODE_SEEK;
         end
      end

      rsp_data_in.char_kind       = kind;
      rsp_data_in.char_out        = ch;
      rsp_data_in.record_start    = rstart;
      rsp_data_in.record_end      = rend;
      rsp_data_in.record_offset   = 32'(start_offset_in);
      // a closing byte reports the length and overflow of the record that just ended
      rsp_data_in.seq_length      = rend ? 16'(residue_count_ff) : 16'(residue_count_in);
      rsp_data_in.overflow        = rend ? overflow_ff : overflow_in;
      rsp_data_in.illegal_skipped = illegal;
      rsp_data_in.header_error    = herr;

      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_SEEK;
         byte_offset_ff   <= '0;
         start_offset_ff  <= '0;
         header_count_ff  <= '0;
         residue_count_ff <= '0;
         overflow_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            mode_ff          <= mode_in;
            byte_offset_ff   <= byte_offset_in;
            start_offset_ff  <= start_offset_in;
            header_count_ff  <= header_count_in;
            residue_count_ff <= residue_count_in;
            overflow_ff      <= overflow_in;
         end
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* verif/fasta_record_parser_core_tb.sv */
// Self-checking testbench for fasta_record_parser_core: directed and random FASTA byte
// streams against a cycle-free parse predictor, with random idling on both channels.
// Depends on frp_pkg and the fasta_record_parser_core RTL.
module fasta_record_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import frp_pkg::*;

   localparam int          SETTLE_CYCLES = 4;       // keep some slack after the last result
   localparam int unsigned CYCLE_LIMIT   = 300000;  // timeout guard for the whole run
   localparam logic [7:0]  CH_AT         = 8'h40;   // '@', stands in for a stray '>' in data

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Bytes waiting to be driven, and parse results waiting to come out.
   req_type     pending_bytes[$];
   rsp_type     awaited_results[$];
   int unsigned bytes_queued = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned recv_stall = 0;
   bit          steady_flow = 1'b0;   // no idling on either side when set
   rsp_type     want_rsp;

   // Predictor state and its copy of the registers.
   parse_mode_type walk_mode = MODE_SEEK;
   logic [31:0]    byte_pos = '0;
   logic [31:0]    rec_start = '0;
   logic [7:0]     hdr_count = '0;
   logic [15:0]    res_count = '0;
   logic           ovf_seen = 1'b0;
   logic [15:0]    cfg_max_res = MAX_RESIDUES_RESET;
   logic [7:0]     cfg_max_hdr = MAX_HEADER_CHARS_RESET;

   fasta_record_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advance the parse predictor by one byte (or end-of-file mark) and return the
   // result the block must give for it.
   function automatic rsp_type parse_step(req_type item);
      rsp_type     res;
      logic [7:0]  c;
      logic [31:0] here;
      logic        closed;
      logic        letter;
      logic        id_gap;
      c      = item.in_byte;
      res    = '0;
      closed = 1'b0;
      letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
      id_gap = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF)
               || (c == CH_CR);
      // a closing step reports the totals of the record it closes
      res.seq_length = res_count;
      res.overflow   = ovf_seen;
      if (item.end_of_file) begin
         if (walk_mode != MODE_SEEK) begin
            closed           = 1'b1;
            res.header_error = (walk_mode == MODE_LEAD);
         end
         walk_mode = MODE_SEEK;
         byte_pos  = '0;
      end else begin
         here     = byte_pos;
         byte_pos = byte_pos + 32'd1;
         case (walk_mode)
            MODE_LEAD, MODE_ID, MODE_DESC: begin
               if (c == CH_LF) begin
                  res.header_error = (walk_mode == MODE_LEAD);
                  walk_mode        = MODE_SEQ;
               end else if (hdr_count < cfg_max_hdr) begin
                  hdr_count = hdr_count + 8'd1;
                  if (walk_mode == MODE_LEAD) begin
                     if (!id_gap) begin
                        res.char_kind = KIND_ID;
                        res.char_out  = c;
                        walk_mode     = MODE_ID;
                     end
                  end else if (walk_mode == MODE_ID) begin
                     if (id_gap) begin
                        walk_mode = MODE_DESC;
                     end else begin
                        res.char_kind = KIND_ID;
                        res.char_out  = c;
                     end
                  end else begin
                     res.char_kind = KIND_DESC;
                     res.char_out  = c;
                  end
               end
            end
            default: begin
               if (c == CH_GT) begin
                  closed           = (walk_mode == MODE_SEQ);
                  res.record_start = 1'b1;
                  walk_mode        = MODE_LEAD;
                  rec_start        = here;
                  hdr_count        = '0;
                  res_count        = '0;
                  ovf_seen         = 1'b0;
               end else if (walk_mode == MODE_SEQ) begin
                  if (letter) begin
                     if ((res_count < cfg_max_res) && (res_count != 16'hFFFF)) begin
                        res_count     = res_count + 16'd1;
                        res.char_kind = KIND_RESIDUE;
                        res.char_out  = c & ~CASE_BIT;
                     end else begin
                        ovf_seen = 1'b1;
                     end
                  end else if ((c != CH_SPACE) && (c != CH_TAB) && (c != CH_LF)
                               && (c != CH_CR)) begin
                     res.illegal_skipped = 1'b1;
                  end
               end
            end
         endcase
      end
      res.record_end = closed;
      if (!closed) begin
         res.seq_length = res_count;
         res.overflow   = ovf_seen;
      end
      res.record_offset = rec_start;
      return res;
   endfunction

   function automatic string rsp_text(rsp_type r);
      return $sformatf({"kind=%0d char=%02h start=%b end=%b offset=%0d len=%0d ",
                        "ovf=%b illegal=%b herr=%b"},
                       r.char_kind, r.char_out, r.record_start, r.record_end,
                       r.record_offset, r.seq_length, r.overflow, r.illegal_skipped,
                       r.header_error);
   endfunction

   task automatic queue_item(logic [7:0] b, logic eof);
      pending_bytes.push_back(req_type'{in_byte: b, end_of_file: eof});
      bytes_queued++;
   endtask

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 4))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_VT;
         3:       return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   // One well-formed record with random content: '>', optional leading blanks, id,
   // separator and description, then a few sequence lines. Occasionally no id at all,
   // and now and then a stray blank or junk byte among the residues.
   task automatic queue_record(int unsigned desc_max);
      int unsigned n_lead;
      int unsigned n_id;
      int unsigned n_desc;
      int unsigned n_lines;
      int unsigned pick;
      logic [7:0]  b;
      n_lead  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      n_id    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      n_desc  = $urandom_range(0, desc_max);
      n_lines = $urandom_range(0, 3);
      queue_item(CH_GT, 1'b0);
      repeat (n_lead) queue_item(blank_byte(), 1'b0);
      repeat (n_id) queue_item(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
      if ((n_id != 0) && ($urandom_range(0, 3) != 0)) begin
         queue_item(blank_byte(), 1'b0);
         repeat (n_desc) begin
            b = ($urandom_range(0, 15) == 0) ? CH_CR : 8'($urandom_range(8'h20, 8'h7E));
            queue_item(b, 1'b0);
         end
      end
      queue_item(CH_LF, 1'b0);
      repeat (n_lines) begin
         repeat ($urandom_range(1, 16)) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
               b = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
            end else if (pick == 1) begin
               b = 8'($urandom_range(0, 255));
               if (b == CH_GT) b = CH_AT;
            end else begin
               b = ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'($urandom_range(0, 25));
            end
            queue_item(b, 1'b0);
         end
         if ($urandom_range(0, 1)) queue_item(CH_CR, 1'b0);
         queue_item(CH_LF, 1'b0);
      end
   endtask

   // Mostly records, some raw noise bytes and end-of-file marks.
   task automatic queue_stream(int unsigned n_bytes);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = bytes_queued + n_bytes;
      while (bytes_queued < stop_at) begin
         pick = $urandom_range(0, 11);
         if (pick < 2) begin
            repeat ($urandom_range(1, 6)) begin
               queue_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            end
         end else if (pick == 2) begin
            queue_item(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            queue_record(12);
         end
      end
   endtask

   // Block is idle once nothing is queued, in flight, or awaited.
   task automatic wait_idle();
      do @(posedge clock);
      while ((pending_bytes.size() != 0) || req_valid || (awaited_results.size() != 0));
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MAX_RESIDUES:     cfg_max_res = val;
         CSR_MAX_HEADER_CHARS: cfg_max_hdr = val[7:0];
         default: ;
      endcase
   endtask

   // Request driver: holds valid and payload until the transaction is taken, predicts
   // the result at acceptance, and inserts random gaps between transactions.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_results.push_back(parse_step(req_data));
         end
         if (req_valid && !req_ready) begin
            // stalled: keep the transaction on the port
         end else if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!steady_flow && ($urandom_range(0, 5) == 0)) begin
            send_gap  <= $urandom_range(0, 4);
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: compares each accepted transaction field by field against the
   // oldest awaited result; rsp_ready drops in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("[%0t] result with none awaited: %s", $time, rsp_text(rsp_data));
               end
            end else begin
               want_rsp = awaited_results.pop_front();
               if ((rsp_data.char_kind !== want_rsp.char_kind)
                   || (rsp_data.char_out !== want_rsp.char_out)
                   || (rsp_data.record_start !== want_rsp.record_start)
                   || (rsp_data.record_end !== want_rsp.record_end)
                   || (rsp_data.record_offset !== want_rsp.record_offset)
                   || (rsp_data.seq_length !== want_rsp.seq_length)
                   || (rsp_data.overflow !== want_rsp.overflow)
                   || (rsp_data.illegal_skipped !== want_rsp.illegal_skipped)
                   || (rsp_data.header_error !== want_rsp.header_error)) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("[%0t] result mismatch", $time);
                     $display("   expected %s", rsp_text(want_rsp));
                     $display("   actual   %s", rsp_text(rsp_data));
                  end
               end
            end
         end
         if (recv_stall != 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready  <= 1'b0;
         end else if (!steady_flow && ($urandom_range(0, 5) == 0)) begin
            recv_stall <= $urandom_range(0, 4);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[%0t] timeout, %0d results still awaited", $time, awaited_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [15:0] res_set[6];
      logic [7:0]  hdr_set[6];
      // register settings per phase: extremes, small limits that bite, random, reset
      res_set[0] = 16'd1;     hdr_set[0] = 8'd1;
      res_set[1] = 16'd65535; hdr_set[1] = 8'd255;
      res_set[2] = 16'd4;     hdr_set[2] = 8'd3;
      res_set[3] = 16'($urandom_range(1, 65535));
      hdr_set[3] = 8'($urandom_range(1, 255));
      res_set[4] = 16'($urandom_range(2, 30));
      hdr_set[4] = 8'($urandom_range(2, 12));
      res_set[5] = MAX_RESIDUES_RESET; hdr_set[5] = MAX_HEADER_CHARS_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through the parser with reset register values.
      queue_item(8'h00, 1'b0);          // junk before any record is skipped
      queue_item(8'hFF, 1'b0);
      queue_item(8'h00, 1'b1);          // end of file while seeking: offset restarts
      queue_item(CH_GT, 1'b0);          // record opens at offset 0
      queue_item(CH_SPACE, 1'b0);       // leading blanks before the id
      queue_item(CH_TAB, 1'b0);
      queue_item(CH_LO_A, 1'b0);        // id byte
      queue_item(CH_GT, 1'b0);          // '>' inside the header is plain header text
      queue_item(CH_CR, 1'b0);          // CR ends the id
      queue_item(CH_LO_A + 8'd3, 1'b0); // description byte
      queue_item(CH_CR, 1'b0);          // CR inside the description is kept
      queue_item(CH_LF, 1'b0);          // header done, sequence follows
      queue_item(CH_LO_A, 1'b0);        // residues get upper-cased
      queue_item(CH_LO_Z, 1'b0);
      queue_item(CH_AT, 1'b0);          // junk in sequence raises the warning
      queue_item(CH_SPACE, 1'b0);       // blank in sequence is silently ignored
      queue_item(8'h80, 1'b0);
      queue_item(CH_GT, 1'b0);          // closes the record and opens the next
      queue_item(CH_LF, 1'b0);          // header with no id
      queue_item(CH_UP_A + 8'd16, 1'b0);
      queue_item(8'hFF, 1'b1);          // end of file closes the record
      queue_item(CH_GT, 1'b0);          // new stream, offset back at 0
      queue_item(8'h7F, 1'b1);          // end of file before any id
      queue_stream(200);

      for (int p = 0; p < 6; p++) begin
         wait_idle();
         steady_flow = (p == 5);
         write_csr(CSR_MAX_RESIDUES, res_set[p]);
         write_csr(CSR_MAX_HEADER_CHARS, {8'd0, hdr_set[p]});
         if (hdr_set[p] == 8'd255) queue_record(300);  // header may run past the limit
         if (p == 2) begin
            // sender holds off until every result is back, then carries on
            queue_stream(120);
            wait_idle();
            queue_stream(120);
         end else begin
            queue_stream(240);
         end
      end

      wait_idle();
      if ((fail_count == 0) && (awaited_results.size() == 0)) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/frp_pkg.sv
rtl/fasta_record_parser_core.sv
verif/fasta_record_parser_core_tb.sv
